// ===== rtl/core/sobel_pkg.sv =====
// Shared constants, types and helpers for the Sobel edge stream.
package sobel_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int CFG_W = 11;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic restart;   // clear positions and counters
    logic wr_pixel;  // store gray of the accepted pixel
    logic rd_start;  // begin window reads for the oldest pending centre
    logic rd_step;   // issue one window read
    logic compute;   // form window sums
    logic finish;    // finish magnitude and load output
  } sob_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic emit_due;    // pending exceeds width+1, or the item is a flush
    logic any_pending; // at least one pending centre
    logic rd_done;     // all nine window reads issued and returned
    logic sqrt_done;   // root iteration finished
  } sob_sts_t;

  // gray = floor((30r+59g+11b)/100)
  function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [14:0] sum;
    logic [31:0] prod;
    sum  = 15'(30 * r) + 15'(59 * g) + 15'(11 * b);
    // reciprocal of 100 scaled by 2^19, exact for sums below 43690
    prod = 32'(sum) * 32'd5243;
    return prod[26:19];
  endfunction

endpackage

// ===== rtl/core/sobel_edge_stream_top.sv =====
// Top level of the streaming 3x3 Sobel edge detector.
// RGB pixels enter in raster order and are reduced to gray; each centre pixel
// yields gray, |Gx|, |Gy| (saturated at 255) and the floor root of their
// squared sum, with last_of_frame marking the frame's final pixel. A result
// appears width+1 pixels after its own pixel; flush transactions (command=1)
// drain pending results one at a time. A transaction that causes a result
// is paced by nine sequential reads through the one read port of the line
// memory and the nine-step bit-pair square root. The output register holds a
// result until taken; a following result waits, with the input stalled, until
// that register frees. A new transaction is taken while no result is in
// progress. A write on the configuration port restarts the stream and drops
// pending results.
module sobel_edge_stream_top #(
  parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red, green, blue
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // gray_level, edge_horizontal, edge_vertical, edge_magnitude
  output logic        m_axis_tlast   // last_of_frame
);
  import sobel_pkg::*;

  sob_cmd_t cmd;
  sob_sts_t sts;
  logic in_fire, out_free, flush_r;
  logic [7:0] g, eh, ev, mg;
  logic lst;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // remember whether the item in progress is a flush
  always_ff @(posedge clk) begin
    if (rst) flush_r <= 1'b0;
    else if (in_fire) flush_r <= (s_axis_tuser == CMD_FLUSH);
  end

  sobel_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .in_fire(in_fire),
    .in_cmd(s_axis_tuser), .out_free(out_free), .sts(sts), .cmd(cmd),
    .in_ready(s_axis_tready)
  );

  sobel_dpath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dpath (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_flush(flush_r),
    .red(s_axis_tdata[7:0]), .green(s_axis_tdata[15:8]), .blue(s_axis_tdata[23:16]),
    .cmd(cmd), .sts(sts), .res_gray(g), .res_eh(eh), .res_ev(ev), .res_mag(mg),
    .res_last(lst)
  );

  // hold the result until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (rst || cfg_we) m_axis_tvalid <= 1'b0;
    else if (cmd.finish) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  assign m_axis_tdata = {mg, ev, eh, g};
  assign m_axis_tlast = lst;
endmodule

// ===== rtl/core/sobel_ctrl.sv =====
// Controller state machine for the Sobel edge stream.
module sobel_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               in_fire,
  input  logic               in_cmd,
  input  logic               out_free,
  input  sobel_pkg::sob_sts_t sts,
  output sobel_pkg::sob_cmd_t cmd,
  output logic               in_ready
);
  import sobel_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_READ, S_CALC, S_SQRT, S_WAIT} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE) && !cfg_we;

  always_comb begin
    cmd = '0;
    cmd.restart  = cfg_we;
    cmd.wr_pixel = in_fire && (in_cmd == CMD_PIXEL);
    cmd.rd_start = (state == S_CHECK);
    cmd.rd_step  = (state == S_READ);
    cmd.compute  = (state == S_CALC);
    cmd.finish   = (state == S_WAIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_cmd == CMD_FLUSH) begin
              if (sts.any_pending) state <= S_CHECK;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          // a pixel only emits once enough lookahead exists
          if (sts.emit_due) state <= S_READ;
          else state <= S_IDLE;
        end
        S_READ: begin
          if (sts.rd_done) state <= S_CALC;
        end
        S_CALC: state <= S_SQRT;
        S_SQRT: begin
          if (sts.sqrt_done) state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/sobel_dpath.sv =====
// Datapath for the Sobel edge stream: line memory, window, sums and root.
module sobel_dpath #(
  parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [sobel_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_flush,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,
  input  sobel_pkg::sob_cmd_t        cmd,
  output sobel_pkg::sob_sts_t        sts,
  output logic [7:0]                 res_gray,
  output logic [7:0]                 res_eh,
  output logic [7:0]                 res_ev,
  output logic [7:0]                 res_mag,
  output logic                       res_last
);
  import sobel_pkg::*;

  localparam int DEPTH = 2 * MAX_WIDTH + 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = $clog2(MAX_WIDTH + 3);

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(640);
      frame_height <= CFG_W'(480);
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_WIDTH) frame_width <= cfg_data;
      else frame_height <= cfg_data;
    end
  end

  always_comb begin
    if (frame_width == '0) w_eff = XW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(frame_width);
    if (frame_height == '0) h_eff = YW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
    else h_eff = YW'(frame_height);
  end

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] write_pos;
  logic [PW-1:0] pending;
  logic [XW-1:0] out_col;
  logic [YW-1:0] out_row;
  logic [AW-1:0] centre;
  logic [3:0]    tap;       // read being issued
  logic          rd_vld;
  logic [3:0]    rd_tap;
  logic [7:0]    rd_data;
  logic [7:0]    win [9];
  logic [8:0]    tap_ok;
  logic          top, bottom, left, right;

  assign top    = (out_row == '0);
  assign bottom = (32'(out_row) >= 32'(h_eff) - 1);
  assign left   = (out_col == '0);
  assign right  = (32'(out_col) >= 32'(w_eff) - 1);

  always_comb begin
    tap_ok[0] = !top && !left;
    tap_ok[1] = !top;
    tap_ok[2] = !top && !right;
    tap_ok[3] = !left;
    tap_ok[4] = 1'b1;
    tap_ok[5] = !right && (32'(pending) > 1);
    tap_ok[6] = !bottom && !left && (32'(pending) > 32'(w_eff) - 1);
    tap_ok[7] = !bottom && (32'(pending) > 32'(w_eff));
    tap_ok[8] = !bottom && !right && (32'(pending) > 32'(w_eff) + 1);
  end

  // ring address of the current tap
  logic signed [AW+2:0] off;
  logic [AW+2:0]        addr_sum;
  logic [AW-1:0]        rd_addr;
  always_comb begin
    case (tap)
      4'd0: off = -$signed({3'b0, AW'(w_eff)}) - (AW+3)'(1);
      4'd1: off = -$signed({3'b0, AW'(w_eff)});
      4'd2: off = -$signed({3'b0, AW'(w_eff)}) + (AW+3)'(1);
      4'd3: off = -(AW+3)'(1);
      4'd4: off = '0;
      4'd5: off = (AW+3)'(1);
      4'd6: off = $signed({3'b0, AW'(w_eff)}) - (AW+3)'(1);
      4'd7: off = $signed({3'b0, AW'(w_eff)});
      4'd8: off = $signed({3'b0, AW'(w_eff)}) + (AW+3)'(1);
      default: off = '0;
    endcase
    addr_sum = (AW+3)'(centre) + (AW+3)'(off);
    if ($signed(addr_sum) < 0) addr_sum = addr_sum + (AW+3)'(DEPTH);
    else if (addr_sum >= (AW+3)'(DEPTH)) addr_sum = addr_sum - (AW+3)'(DEPTH);
    rd_addr = addr_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_pixel) mem[write_pos] <= gray_of(red, green, blue);
    rd_data <= mem[rd_addr];
  end

  logic [AW-1:0] cdiff;
  always_comb begin
    if (write_pos >= AW'(pending)) cdiff = write_pos - AW'(pending);
    else cdiff = AW'(32'(write_pos) + DEPTH - 32'(pending));
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      write_pos <= '0;
      pending   <= '0;
      out_col   <= '0;
      out_row   <= '0;
      tap       <= '0;
      rd_vld    <= 1'b0;
      rd_tap    <= '0;
    end else begin
      if (cmd.wr_pixel) begin
        write_pos <= (32'(write_pos) == DEPTH - 1) ? '0 : write_pos + 1'b1;
        pending   <= pending + 1'b1;
      end
      if (cmd.rd_start) begin
        centre <= cdiff;
        tap    <= '0;
      end
      rd_vld <= cmd.rd_step && (tap < 4'd9);
      rd_tap <= tap;
      if (cmd.rd_step && tap < 4'd9) tap <= tap + 1'b1;
      if (rd_vld) win[rd_tap] <= tap_ok[rd_tap] ? rd_data : 8'd0;
      if (cmd.finish) begin
        pending <= pending - 1'b1;
        if (32'(out_col) + 1 >= 32'(w_eff)) begin
          out_col <= '0;
          out_row <= (32'(out_row) + 1 >= 32'(h_eff)) ? '0 : out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  assign sts.emit_due    = 32'(pending) > 32'(w_eff) + 1 || in_flush;
  assign sts.any_pending = (pending != '0);
  assign sts.rd_done     = (tap == 4'd9) && !rd_vld;

  // window sums
  logic signed [11:0] gx, gy;
  logic [7:0] ex, ey;
  always_comb begin
    gx = 12'(win[0]) - 12'(win[2]) + 12'({win[3], 1'b0}) - 12'({win[5], 1'b0})
       + 12'(win[6]) - 12'(win[8]);
    gy = 12'(win[6]) + 12'({win[7], 1'b0}) + 12'(win[8])
       - 12'(win[0]) - 12'({win[1], 1'b0}) - 12'(win[2]);
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    ex = (gx > 12'sd255) ? 8'd255 : gx[7:0];
    ey = (gy > 12'sd255) ? 8'd255 : gy[7:0];
  end

  // bit-pair root, one step per cycle
  logic [16:0] sq_v;
  logic [16:0] sq_root;
  logic [16:0] sq_bit;
  logic [7:0]  eh_r, ev_r;
  logic        sq_busy;
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      sq_busy <= 1'b0;
    end else if (cmd.compute) begin
      eh_r    <= ex;
      ev_r    <= ey;
      sq_v    <= 17'(16'(ex) * 16'(ex)) + 17'(16'(ey) * 16'(ey));
      sq_root <= '0;
      sq_bit  <= 17'h10000;
      sq_busy <= 1'b1;
    end else if (sq_busy) begin
      if (sq_bit == '0) begin
        sq_busy <= 1'b0;
      end else begin
        if (sq_v >= sq_root + sq_bit) begin
          sq_v    <= sq_v - (sq_root + sq_bit);
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
    end
  end
  assign sts.sqrt_done = sq_busy && (sq_bit == '0);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_gray <= win[4];
      res_eh   <= eh_r;
      res_ev   <= ev_r;
      res_mag  <= (sq_root > 17'd255) ? 8'd255 : sq_root[7:0];
      res_last <= bottom && right;
    end
  end
endmodule
